// File: hdl/hte_pkg.sv
// package for the huffman table encoder: transaction payload types, func codes and constants
// used by hdl/huffman_table_encoder.sv; no dependencies
package hte_pkg;

  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int SYM_W            = 8;
  localparam int BYTE_W           = 8;
  localparam int FLUSH_MAX        = 4;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int ACC_BITS_DEF     = 32;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [SYM_W-1:0]   symbol;
    logic [CODE_W-1:0]  code_word;
    logic [LEN_W-1:0]   code_len;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              err;
  } result_t;

  // one table entry as held in the ram
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage

// File: hdl/hte_ram.sv
// generic single-port-write ram with registered read, read data holds when not enabled
// no dependencies
module hte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/huffman_table_encoder.sv
// huffman table encoder: table read at the accepting edge, output register loaded by the
// packing stage once a byte is ready and the output has space; one item per cycle when each
// item yields at most one byte and the output does not stall, else one byte per step
// reset: entry valid flags, bit count and all handshake state clear; the code table itself
// is left as it is and needs no clearing pass
// depends on hdl/hte_pkg.sv and hdl/hte_ram.sv
module huffman_table_encoder
  import hte_pkg::*;
#(
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int ACC_BITS     = ACC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int AW      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int HW      = $clog2(ACC_BITS + 1);
  localparam int SW      = HW + 1;
  localparam int ENT_W   = CODE_W + LEN_W;
  localparam int MAX_LEN = (ACC_BITS < CODE_W) ? ACC_BITS : CODE_W;
  localparam int FC_W    = $clog2(FLUSH_MAX);

  // input side
  logic              accept;
  logic              sym_ok;
  logic [AW-1:0]     idx;
  logic [LEN_W-1:0]  sat_len;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [ENT_W-1:0]  rd_bits;
  logic [SYMBOL_COUNT-1:0] entry_valid;

  // packing stage
  logic              s2_valid;
  logic              s2_first;
  func_t             s2_func;
  logic              s2_hit;
  logic [ACC_BITS-1:0] acc;
  logic [HW-1:0]     held;
  logic [LEN_W-1:0]  len_rem;
  logic [CODE_W-1:0] code_rem;
  logic [FC_W-1:0]   fcnt;

  logic [ACC_BITS-1:0] acc_next;
  logic [HW-1:0]     held_next;
  logic [LEN_W-1:0]  len_next;
  logic [CODE_W-1:0] code_next;
  logic [FC_W-1:0]   fcnt_next;

  logic [LEN_W-1:0]  cur_len;
  logic [CODE_W-1:0] cur_code;
  logic [ACC_BITS-1:0] code_x;
  logic [SW-1:0]     sum;
  logic              over;
  logic              held_ge8;
  logic [HW-1:0]     take;
  logic [LEN_W-1:0]  rem_len;
  logic [CODE_W-1:0] rem_code;
  logic [BYTE_W-1:0] top_byte;
  logic [BYTE_W-1:0] pad_byte;
  logic [BYTE_W-1:0] mixed_byte;

  logic              emit;
  logic              finish;
  logic              step_go;
  logic              s2_done;
  logic              out_space;
  result_t           res_next;

  // ---------------------------------------------------------------------------------------
  // accept and table access

  assign item_ready = !s2_valid || s2_done;
  assign accept     = item_valid && item_ready;
  assign sym_ok     = {1'b0, item.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx        = item.symbol[AW-1:0];
  assign sat_len    = (item.code_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : item.code_len;

  always_comb begin
    wr_entry.code = item.code_word;
    wr_entry.len  = sat_len;
  end

  hte_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (accept && item.func == FUNC_LOAD && sym_ok),
    .waddr (idx),
    .wdata (wr_entry),
    .re    (accept && item.func == FUNC_ENCODE),
    .raddr (idx),
    .rdata (rd_bits)
  );

  assign rd_entry = entry_t'(rd_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (accept && item.func == FUNC_LOAD && sym_ok) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // packing datapath

  assign cur_len  = s2_first ? rd_entry.len : len_rem;
  assign cur_code = (s2_first ? rd_entry.code : code_rem) & ~({CODE_W{1'b1}} << cur_len);
  assign code_x   = ACC_BITS'(cur_code);
  assign sum      = SW'(held) + SW'(cur_len);
  assign over     = sum > SW'(ACC_BITS);
  assign held_ge8 = held >= HW'(BYTE_W);

  // bits above held are stale; every byte taken below is cut to its low eight bits
  assign take       = HW'(BYTE_W) - held;
  assign top_byte   = BYTE_W'(acc >> (held - HW'(BYTE_W)));
  assign pad_byte   = BYTE_W'(acc << take);
  assign rem_len    = cur_len - LEN_W'(take);
  assign rem_code   = cur_code & ~({CODE_W{1'b1}} << rem_len);
  assign mixed_byte = pad_byte | BYTE_W'(cur_code >> rem_len);

  always_comb begin
    emit      = 1'b0;
    finish    = 1'b0;
    res_next  = '0;
    acc_next  = acc;
    held_next = held;
    len_next  = cur_len;
    code_next = cur_code;
    fcnt_next = fcnt;
    if (s2_valid) begin
      unique case (s2_func)
        FUNC_ENCODE: begin
          if (!s2_hit) begin
            emit         = 1'b1;
            finish       = 1'b1;
            res_next.err = 1'b1;
          end else if (!over) begin
            finish    = 1'b1;
            acc_next  = (acc << cur_len) | code_x;
            held_next = held + HW'(cur_len);
          end else if (held_ge8) begin
            emit              = 1'b1;
            res_next.out_byte = top_byte;
            if (sum - SW'(BYTE_W) <= SW'(ACC_BITS)) begin
              // room after this byte: append in the same step
              finish    = 1'b1;
              acc_next  = (acc << cur_len) | code_x;
              held_next = held - HW'(BYTE_W) + HW'(cur_len);
            end else begin
              held_next = held - HW'(BYTE_W);
            end
          end else begin
            // fewer than eight held and still no room: byte straddles into the code
            emit              = 1'b1;
            finish            = 1'b1;
            res_next.out_byte = mixed_byte;
            acc_next          = ACC_BITS'(rem_code);
            held_next         = HW'(rem_len);
          end
        end
        FUNC_FLUSH: begin
          if (held == '0) begin
            finish = 1'b1;
          end else begin
            emit = 1'b1;
            if (held_ge8) begin
              res_next.out_byte = top_byte;
              held_next         = held - HW'(BYTE_W);
            end else begin
              res_next.out_byte = pad_byte;
              held_next         = '0;
            end
            finish    = (held_next == '0) || (fcnt == FC_W'(FLUSH_MAX - 1));
            fcnt_next = fcnt + FC_W'(1);
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
    res_next.last = finish;
  end

  assign out_space = !result_valid || result_ready;
  assign step_go   = s2_valid && (!emit || out_space);
  assign s2_done   = step_go && finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_first <= 1'b0;
      held     <= '0;
      acc      <= '0;
      fcnt     <= '0;
    end else begin
      if (step_go) begin
        acc      <= acc_next;
        held     <= held_next;
        len_rem  <= len_next;
        code_rem <= code_next;
      end
      if (accept) begin
        s2_valid <= 1'b1;
        s2_first <= 1'b1;
        s2_func  <= item.func;
        s2_hit   <= sym_ok && entry_valid[idx];
        fcnt     <= '0;
      end else if (step_go) begin
        s2_first <= 1'b0;
        fcnt     <= fcnt_next;
        if (finish) begin
          s2_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // output register

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_go && emit) begin
      result_valid <= 1'b1;
      result       <= res_next;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_held_bound : assert property (@(posedge clk) disable iff (rst)
    held <= HW'(ACC_BITS))
    else $error("bit count above accumulator size");

  a_err_is_last : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.err |-> result.last)
    else $error("error transaction not marked last");

  a_miss_keeps_state : assert property (@(posedge clk) disable iff (rst)
    step_go && s2_func == FUNC_ENCODE && !s2_hit |=> $stable(held))
    else $error("unloaded symbol changed the bit count");

  a_fresh_count : assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_first |-> fcnt == '0)
    else $error("flush byte count not cleared for new transaction");
`endif

endmodule
